>>> sv/twfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tree walk feature contribution package
// Shared widths, opcodes and sequencer states for the contribution core.
// ----------------------------------------------------------------------------
package twfc_pkg;

  localparam int unsigned MaxNodes    = 256;
  localparam int unsigned MaxTrees    = 16;
  localparam int unsigned MaxFeatures = 32;
  localparam int unsigned MaxClasses  = 8;

  localparam int unsigned NodeW  = $clog2(MaxNodes);
  localparam int unsigned TreeW  = $clog2(MaxTrees);
  localparam int unsigned SlotW  = NodeW + TreeW;
  localparam int unsigned ClassW = $clog2(MaxClasses);
  localparam int unsigned IncW   = SlotW + ClassW;
  localparam int unsigned ValW   = 48;
  localparam int unsigned FeatW  = 5;
  localparam int unsigned CntW   = 5;
  localparam int unsigned StepW  = NodeW + 1;

  typedef enum logic [2:0] {
    OpWriteNode = 3'd0,
    OpWriteInc  = 3'd1,
    OpWriteFeat = 3'd2,
    OpEval      = 3'd3,
    OpRead      = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StFetch,
    StNode,
    StSample,
    StDecide,
    StIncRead,
    StIncWait,
    StAccum,
    StRdSum,
    StDivide,
    StOut
  } state_e;

endpackage
`default_nettype wire

>>> sv/tree_walk_feature_contribution_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tree walk feature contribution core
// Walks one decision tree per evaluate and sums per-feature increments;
// a read returns a sum divided by the tree count and clears it.
// ----------------------------------------------------------------------------
// Channel     | Direction | Contents
// s_axis      | in        | command item (opcode, indexes, value, flags)
// m_axis      | out       | result item (status, leaf, feature, contribution)
// cfg         | in        | tree_count write, no read-back
//
// A read runs one quotient bit per cycle through the restoring divider; an
// evaluate steps through each tree level reading the node, sample and
// increment memories one after another.
// Reset clears the sums (valid bits) and control and sets the tree count to 1; no memory sweep.
// The result is held in an output register until taken; no item is accepted
// until then.

module tree_walk_feature_contribution_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: opcode[2:0], tree_index[6:3], node_index[14:7], left_child[22:15],
  // right_child[30:23], leaf_flag[31], feature_index[36:32], value[84:37],
  // class_index[87:85], numeric_flag[88], zero fill to 96
  input  wire logic [95:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: status[0], leaf_reached[8:1], out_feature[13:9],
  // contribution[61:14], zero fill to 64
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i
);

  localparam int unsigned VW = twfc_pkg::ValW;

  // Input fields.
  logic [2:0]                   in_op;
  logic [twfc_pkg::TreeW-1:0]   in_tree;
  logic [twfc_pkg::NodeW-1:0]   in_node, in_lc, in_rc;
  logic                         in_leaf, in_num;
  logic [twfc_pkg::FeatW-1:0]   in_feat;
  logic [VW-1:0]                in_val;
  logic [twfc_pkg::ClassW-1:0]  in_cls;

  assign in_op   = s_axis_tdata[2:0];
  assign in_tree = s_axis_tdata[6:3];
  assign in_node = s_axis_tdata[14:7];
  assign in_lc   = s_axis_tdata[22:15];
  assign in_rc   = s_axis_tdata[30:23];
  assign in_leaf = s_axis_tdata[31];
  assign in_feat = s_axis_tdata[36:32];
  assign in_val  = s_axis_tdata[84:37];
  assign in_cls  = s_axis_tdata[87:85];
  assign in_num  = s_axis_tdata[88];

  // Memories.
  localparam int unsigned NodeRecW = 2 * twfc_pkg::NodeW + 1 + twfc_pkg::FeatW + VW;
  logic [NodeRecW-1:0] node_mem [twfc_pkg::MaxTrees*twfc_pkg::MaxNodes];
  logic [VW-1:0]       inc_mem  [twfc_pkg::MaxTrees*twfc_pkg::MaxNodes*twfc_pkg::MaxClasses];
  logic [VW:0]         samp_mem [twfc_pkg::MaxFeatures];
  logic [VW-1:0]       sum_mem  [twfc_pkg::MaxFeatures];
  logic [twfc_pkg::MaxFeatures-1:0] sum_vld_q, sum_vld_d;

  twfc_pkg::state_e state_q, state_d;
  logic [twfc_pkg::CntW-1:0]   tc_q;
  logic [twfc_pkg::TreeW-1:0]  tree_q;
  logic [twfc_pkg::NodeW-1:0]  k_q, k_d;
  logic [twfc_pkg::StepW-1:0]  steps_q, steps_d;
  logic [twfc_pkg::ClassW-1:0] cls_q;
  logic [twfc_pkg::FeatW-1:0]  feat_q, feat_d;
  logic                        rd_q;
  logic [NodeRecW-1:0] node_rd_q;
  logic [VW-1:0]       inc_rd_q, sum_rd_q;
  logic [VW:0]         samp_rd_q;
  logic [VW-1:0]       split_q;
  logic                go_left_d;
  // Divider registers.
  logic [VW-1:0]       quo_q, quo_d, rem_q, rem_d;
  logic [5:0]          dcnt_q, dcnt_d;
  logic                dneg_q, dneg_d;
  // Output register.
  logic [63:0]         out_q, out_d;
  logic                ovld_q, ovld_d;

  // Node record fields.
  logic [twfc_pkg::NodeW-1:0] n_lc, n_rc;
  logic                       n_leaf;
  logic [twfc_pkg::FeatW-1:0] n_feat;
  assign {n_lc, n_rc, n_leaf, n_feat} = node_rd_q[NodeRecW-1:VW];

  logic [twfc_pkg::SlotW-1:0] walk_slot;
  assign walk_slot = {tree_q, k_q};

  logic accept;
  assign s_axis_tready = (state_q == twfc_pkg::StIdle) && !ovld_q;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata = out_q;

  // Saturating add of increment into the feature sum (one adder).
  logic [VW-1:0] sum_cur, sat_sum;
  logic [VW:0]   raw_sum;
  assign sum_cur = sum_vld_q[feat_q] ? sum_rd_q : '0;
  assign raw_sum = {sum_cur[VW-1], sum_cur} + {inc_rd_q[VW-1], inc_rd_q};
  always_comb begin
    if (raw_sum[VW] != raw_sum[VW-1]) begin
      sat_sum = raw_sum[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      sat_sum = raw_sum[VW-1:0];
    end
  end

  // Branch decision from sample and split.
  logic [VW-1:0] sx, sabs;
  logic [VW-17:0] cat;
  logic           snum;
  always_comb begin
    sx   = samp_rd_q[VW-1:0];
    snum = samp_rd_q[VW];
    sabs = sx[VW-1] ? (~sx + 1'b1) : sx;
    cat  = sabs[VW-1:16];
    if (snum) begin
      go_left_d = $signed(sx) <= $signed(split_q);
    end else if (sx[VW-1] || cat == '0 || cat > (VW-16)'(48)) begin
      go_left_d = 1'b0;
    end else begin
      go_left_d = split_q[6'(cat - 1'b1)];
    end
  end

  // Divisor and trial subtraction for the divider.
  logic [VW-1:0] dvs, trial_rem;
  logic [VW:0]   trial;
  assign dvs = (tc_q == '0) ? VW'(1) : VW'(tc_q);
  assign trial_rem = {rem_q[VW-2:0], quo_q[VW-1]};
  assign trial = {1'b0, trial_rem} - {1'b0, dvs};

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    steps_d   = steps_q;
    feat_d    = feat_q;
    sum_vld_d = sum_vld_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dcnt_d    = dcnt_q;
    dneg_d    = dneg_q;
    out_d     = out_q;
    ovld_d    = ovld_q && !m_axis_tready;
    case (state_q)
      twfc_pkg::StIdle: begin
        if (accept) begin
          out_d = '0;
          case (in_op)
            twfc_pkg::OpEval: begin
              k_d = '0;
              steps_d = '0;
              state_d = twfc_pkg::StFetch;
            end
            twfc_pkg::OpRead: begin
              out_d[13:9] = in_feat;
              feat_d = in_feat;
              state_d = twfc_pkg::StRdSum;
            end
            default: begin
              ovld_d = 1'b1;
            end
          endcase
        end
      end
      twfc_pkg::StFetch: state_d = twfc_pkg::StNode;
      twfc_pkg::StNode: begin
        feat_d = n_feat;
        if (n_leaf) begin
          out_d[8:1] = k_q;
          ovld_d = 1'b1;
          state_d = twfc_pkg::StIdle;
        end else if (steps_q >= twfc_pkg::StepW'(twfc_pkg::MaxNodes)) begin
          out_d[0] = 1'b1;
          ovld_d = 1'b1;
          state_d = twfc_pkg::StIdle;
        end else begin
          state_d = twfc_pkg::StSample;
        end
      end
      twfc_pkg::StSample: state_d = twfc_pkg::StDecide;
      twfc_pkg::StDecide: begin
        k_d = go_left_d ? n_lc : n_rc;
        steps_d = steps_q + 1'b1;
        state_d = twfc_pkg::StIncRead;
      end
      twfc_pkg::StIncRead: state_d = twfc_pkg::StIncWait;
      twfc_pkg::StIncWait: state_d = twfc_pkg::StAccum;
      twfc_pkg::StAccum: begin
        sum_vld_d[feat_q] = 1'b1;
        state_d = twfc_pkg::StFetch;
      end
      twfc_pkg::StRdSum: state_d = twfc_pkg::StDivide;
      twfc_pkg::StDivide: begin
        if (dcnt_q == '0) begin
          dneg_d = sum_cur[VW-1];
          quo_d  = sum_cur[VW-1] ? (~sum_cur + 1'b1) : sum_cur;
          rem_d  = '0;
          dcnt_d = 6'(VW);
        end else begin
          if (!trial[VW]) begin
            rem_d = trial[VW-1:0];
            quo_d = {quo_q[VW-2:0], 1'b1};
          end else begin
            rem_d = trial_rem;
            quo_d = {quo_q[VW-2:0], 1'b0};
          end
          dcnt_d = dcnt_q - 1'b1;
          if (dcnt_q == 6'd1) state_d = twfc_pkg::StOut;
        end
      end
      twfc_pkg::StOut: begin
        out_d[61:14] = dneg_q ? (~quo_q + 1'b1) : quo_q;
        sum_vld_d[feat_q] = 1'b0;
        ovld_d = 1'b1;
        state_d = twfc_pkg::StIdle;
      end
      default: state_d = twfc_pkg::StIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= twfc_pkg::StIdle;
      tc_q      <= twfc_pkg::CntW'(1);
      sum_vld_q <= '0;
      ovld_q    <= 1'b0;
      dcnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      sum_vld_q <= sum_vld_d;
      ovld_q    <= ovld_d;
      dcnt_q    <= dcnt_d;
      if (cfg_we_i) tc_q <= cfg_wdata_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    steps_q   <= steps_d;
    feat_q    <= feat_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    dneg_q    <= dneg_d;
    out_q     <= out_d;
    if (accept) begin
      tree_q <= in_tree;
      cls_q  <= in_cls;
      rd_q   <= (in_op == twfc_pkg::OpRead);
    end
  end

  // Memory ports.
  always_ff @(posedge clk_i) begin
    if (accept && in_op == twfc_pkg::OpWriteNode) begin
      node_mem[{in_tree, in_node}] <= {in_lc, in_rc, in_leaf, in_feat, in_val};
    end
    node_rd_q <= node_mem[walk_slot];
    split_q   <= node_rd_q[VW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_op == twfc_pkg::OpWriteInc) begin
      inc_mem[{in_tree, in_node, in_cls}] <= in_val;
    end
    inc_rd_q <= inc_mem[{walk_slot, cls_q}];
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_op == twfc_pkg::OpWriteFeat) begin
      samp_mem[in_feat] <= {in_num, in_val};
    end
    samp_rd_q <= samp_mem[feat_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == twfc_pkg::StAccum) begin
      sum_mem[feat_q] <= sat_sum;
    end
    sum_rd_q <= sum_mem[feat_q];
  end

  // Checks.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == twfc_pkg::StIdle)
    else $error("ready outside idle");
  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == twfc_pkg::StOut |=> !sum_vld_q[$past(feat_q)])
    else $error("read did not clear sum");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == twfc_pkg::StOut) |-> rd_q && dcnt_q == '0)
    else $error("divider finished early");

endmodule
`default_nettype wire
